// File: design/dtpt_pkg.sv
// Shared types, register indexes and helper functions for the dual touch point tracker.
// No dependencies; every other design file imports this package.
package dtpt_pkg;

  localparam int CoordW = 16;
  localparam int HoldW  = 10;
  localparam int WinW   = 12;
  localparam int CfgW   = 12;
  localparam int CfgIdxW = 2;

  typedef logic [CoordW-1:0] coord_t;
  // Both points of one report, indexed [finger][axis]; axis 0 is X and axis 1 is Y.
  // Packed so that finger one X sits in the lowest bits, then Y1, X2 and Y2.
  typedef logic [1:0][1:0][CoordW-1:0] pts_t;

  typedef struct packed {
    logic nz;
    logic neg;
  } spd_sign_t;

  typedef spd_sign_t [1:0][1:0] sign_set_t;

  typedef struct packed {
    logic step;
    logic clear;
  } hist_ctl_t;

  typedef struct packed {
    logic rev_x;
    logic rev_y;
    logic empty;
  } hist_stat_t;

  localparam logic [CfgIdxW-1:0] REG_SINGLE_HOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PAIR_HOLD   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SWAP_WIN_Y  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SWAP_WIN_X  = 2'd3;

  localparam logic [HoldW-1:0] SINGLE_HOLD_RESET = 10'd10;
  localparam logic [HoldW-1:0] PAIR_HOLD_RESET   = 10'd10;
  localparam logic [WinW-1:0]  SWAP_WIN_Y_RESET  = 12'd250;
  localparam logic [WinW-1:0]  SWAP_WIN_X_RESET  = 12'd200;

  function automatic coord_t abs_diff(input coord_t a, input coord_t b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // A reversal needs both speeds nonzero and of opposite sign.
  function automatic logic reversed(input spd_sign_t now, input spd_sign_t prior);
    reversed = now.nz && prior.nz && (now.neg != prior.neg);
  endfunction

endpackage

// File: design/dtpt_pair.sv
// Pairs the raw X and Y values of a two-finger report by Manhattan distance.
// Depends on dtpt_pkg.
module dtpt_pair (
  input  dtpt_pkg::pts_t   raw,
  input  dtpt_pkg::coord_t last_x,
  input  dtpt_pkg::coord_t last_y,
  output dtpt_pkg::pts_t   paired
);
  import dtpt_pkg::*;

  coord_t            dx [2];
  coord_t            dy [2];
  logic [CoordW:0]   cand_d [4];
  logic [CoordW:0]   best_d;
  logic [1:0]        best;

  always_comb begin
    for (int f = 0; f < 2; f++) begin
      dx[f] = abs_diff(raw[f][0], last_x);
      dy[f] = abs_diff(raw[f][1], last_y);
    end
    // Candidate bit 0 picks the X source, bit 1 the Y source.
    for (int i = 0; i < 4; i++) begin
      cand_d[i] = {1'b0, dx[i % 2]} + {1'b0, dy[i / 2]};
    end
    best   = 2'd0;
    best_d = cand_d[0];
    // Strict compare: on a tie the earlier candidate stays.
    for (int i = 1; i < 4; i++) begin
      if (cand_d[i] < best_d) begin
        best_d = cand_d[i];
        best   = 2'(i);
      end
    end
    paired[0][0] = raw[best[0]][0];
    paired[0][1] = raw[best[1]][1];
    paired[1][0] = raw[~best[0]][0];
    paired[1][1] = raw[~best[1]][1];
  end

endmodule

// File: design/dtpt_hist.sv
// Point history of the two-finger path: hold of small moves, entry count and speed signs.
// Depends on dtpt_pkg.
module dtpt_hist #(
  parameter int DEPTH = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dtpt_pkg::pts_t          pts,
  input  logic [9:0]              hold_limit,
  input  dtpt_pkg::hist_ctl_t     ctl,
  output dtpt_pkg::hist_stat_t    stat
);
  import dtpt_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  pts_t            hist [DEPTH];
  pts_t            hist_next [DEPTH];
  pts_t            shift_src [DEPTH];
  pts_t            newest;
  pts_t            held;
  pts_t            wr;
  pts_t            newest_post;
  pts_t            oldest_post;
  logic [CntW-1:0] count;
  logic [CntW-1:0] inc;
  logic [CntW-1:0] slot;
  logic [CntW-1:0] kept;
  logic            full;
  logic            have_prev;
  logic            reject;
  logic            zero_spd;
  sign_set_t       last_sign;
  sign_set_t       sign_now;

  for (genvar i = 0; i < DEPTH - 1; i++) begin : g_shift
    assign shift_src[i] = hist[i + 1];
  end
  assign shift_src[DEPTH-1] = hist[DEPTH-1];

  always_comb begin
    full      = (count == CntW'(DEPTH));
    inc       = full ? count : count + 1'b1;
    slot      = inc - 1'b1;
    have_prev = (count != '0);
    // The newest stored entry is the one compared against; a repeated point or a
    // shared coordinate is not kept.
    reject = have_prev && ((pts == newest) ||
                           (pts[0][1] == pts[1][1]) || (pts[0][0] == pts[1][0]));
    for (int f = 0; f < 2; f++) begin
      for (int a = 0; a < 2; a++) begin
        held[f][a] = (abs_diff(pts[f][a], newest[f][a]) < {6'd0, hold_limit}) ?
                     newest[f][a] : pts[f][a];
      end
    end
    wr          = have_prev ? held : pts;
    kept        = reject ? slot : inc;
    newest_post = reject ? newest : wr;
    if (full) begin
      oldest_post = hist[1];
    end else if (have_prev) begin
      oldest_post = hist[0];
    end else begin
      oldest_post = wr;
    end
    zero_spd = (kept == CntW'(1));
    for (int f = 0; f < 2; f++) begin
      for (int a = 0; a < 2; a++) begin
        sign_now[f][a].nz  = !zero_spd && (newest_post[f][a] != oldest_post[f][a]);
        sign_now[f][a].neg = !zero_spd && (newest_post[f][a] < oldest_post[f][a]);
      end
    end
    stat.rev_y = reversed(sign_now[0][1], last_sign[0][1]) ||
                 reversed(sign_now[1][1], last_sign[1][1]);
    stat.rev_x = reversed(sign_now[0][0], last_sign[0][0]) ||
                 reversed(sign_now[1][0], last_sign[1][0]);
    stat.empty = (count == '0);

    // A full history drops its oldest entry even when the new one is not kept.
    for (int i = 0; i < DEPTH; i++) begin
      hist_next[i] = hist[i];
      if (ctl.step) begin
        if (!reject && (slot == CntW'(i))) begin
          hist_next[i] = wr;
        end else if (full) begin
          hist_next[i] = shift_src[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      last_sign <= '0;
    end else begin
      if (ctl.step) begin
        last_sign <= sign_now;
      end
      if (ctl.clear) begin
        count <= '0;
      end else if (ctl.step) begin
        count <= kept;
      end
    end
  end

  always_ff @(posedge clk) begin
    hist <= hist_next;
    if (ctl.step) begin
      newest <= newest_post;
    end
  end

endmodule

// File: design/dual_touch_point_tracker_core.sv
// Top level of the dual touch point tracker: stream ports, configuration registers,
// input and result registers, hold and swap logic. Depends on dtpt_pkg, dtpt_pair, dtpt_hist.
//
//  Channel   Direction  Handshake                  Payload
//  s_axis    in         s_axis_tvalid/tready       tdata: raw_x1, raw_y1, raw_x2, raw_y2
//  m_axis    out        m_axis_tvalid/tready       tdata: first/second X,Y; tuser: down flags
//  cfg       in         cfg_we (no wait)           cfg_index, cfg_data
//
// One item per cycle sustained while the result is not stalled; an item passes through
// the input register and then leaves from the result register.
// The rate is set by the tracking loop: last points, history and speed signs are
// updated in the same cycle that the item moves into the result register.
// Reset clears both valid flags, the tracked points, the history count and the speeds.
// A stalled result holds the item in the input register; the input is still taken
// whenever the result register drains or is empty.
module dual_touch_point_tracker_core #(
  parameter int HISTORY_DEPTH = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // raw_x1, raw_y1, raw_x2, raw_y2
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // first_x, first_y, second_x, second_y
  output logic [1:0]  m_axis_tuser,   // first_down, second_down
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import dtpt_pkg::*;

  logic [HoldW-1:0] single_hold_limit;
  logic [HoldW-1:0] pair_hold_limit;
  logic [WinW-1:0]  swap_window_y;
  logic [WinW-1:0]  swap_window_x;

  pts_t       in_pts;
  logic       in_valid;
  pts_t       out_pts;
  logic [1:0] out_down;
  logic       out_valid;
  pts_t       last_pts;
  logic       was_down;

  logic       advance;
  logic       down1;
  logic       down2;
  logic       single_hold;
  logic       swap_y;
  logic       swap_x;
  pts_t       paired;
  pts_t       c_next;
  hist_ctl_t  hctl;
  hist_stat_t hstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      single_hold_limit <= SINGLE_HOLD_RESET;
      pair_hold_limit   <= PAIR_HOLD_RESET;
      swap_window_y     <= SWAP_WIN_Y_RESET;
      swap_window_x     <= SWAP_WIN_X_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SINGLE_HOLD: single_hold_limit <= cfg_data[HoldW-1:0];
        REG_PAIR_HOLD:   pair_hold_limit   <= cfg_data[HoldW-1:0];
        REG_SWAP_WIN_Y:  swap_window_y     <= cfg_data[WinW-1:0];
        REG_SWAP_WIN_X:  swap_window_x     <= cfg_data[WinW-1:0];
        default: ;
      endcase
    end
  end

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  dtpt_pair u_pair (
    .raw    (in_pts),
    .last_x (last_pts[0][0]),
    .last_y (last_pts[0][1]),
    .paired (paired)
  );

  dtpt_hist #(
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk        (clk),
    .rst        (rst),
    .pts        (paired),
    .hold_limit (pair_hold_limit),
    .ctl        (hctl),
    .stat       (hstat)
  );

  always_comb begin
    down1 = |in_pts[0];
    down2 = |in_pts[1];
    single_hold = (abs_diff(last_pts[0][0], in_pts[0][0]) < {6'd0, single_hold_limit}) &&
                  (abs_diff(last_pts[0][1], in_pts[0][1]) < {6'd0, single_hold_limit});
    // The swap windows compare the gaps of the paired points; swapping X leaves the
    // X gap unchanged, so both checks may use the paired values.
    swap_y = hstat.rev_y &&
             (abs_diff(paired[0][1], paired[1][1]) < {4'd0, swap_window_y});
    swap_x = hstat.rev_x &&
             (abs_diff(paired[0][0], paired[1][0]) < {4'd0, swap_window_x});

    if (!down2) begin
      c_next = single_hold ? last_pts : in_pts;
    end else if (!was_down) begin
      c_next = in_pts;
    end else begin
      c_next = paired;
      if (swap_y) begin
        c_next[0][0] = paired[1][0];
        c_next[1][0] = paired[0][0];
      end
      if (swap_x) begin
        c_next[0][1] = paired[1][1];
        c_next[1][1] = paired[0][1];
      end
    end

    hctl.step  = advance && down2 && was_down;
    hctl.clear = advance && (!down2 || (was_down && (swap_x || swap_y)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      last_pts  <= '0;
      was_down  <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        last_pts  <= c_next;
        was_down  <= down1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_pts <= s_axis_tdata;
    end
    if (advance) begin
      out_pts  <= c_next;
      out_down <= {down2, down1};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_pts;
  assign m_axis_tuser  = out_down;

  // The input side only stalls behind a full result register that is not drained.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && out_valid && !m_axis_tready))
    else $error("input stalled without a blocked result");

  // A one-finger report always leaves the history empty.
  a_single_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && !down2) |=> hstat.empty)
    else $error("history not emptied after a one-finger report");

  // Reset leaves both register stages empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!in_valid && !out_valid))
    else $error("register stages not empty after reset");

endmodule
